>>> rtl/tcs_pkg.sv
package tcs_pkg;

  // screen and history geometry
  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned HIST_ROWS  = 128;
  localparam int unsigned SCR_CELLS  = ROWS * COLUMNS;
  localparam int unsigned HIST_CELLS = HIST_ROWS * COLUMNS;
  localparam int unsigned SCR_AW     = $clog2(SCR_CELLS);
  localparam int unsigned HIST_AW    = $clog2(HIST_CELLS);

  // field widths
  localparam int unsigned REQ_W   = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ROW_W   = 6;
  localparam int unsigned CELL_W  = 16;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned PROD_W  = 2 * BYTE_W;

  localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0720;
  localparam logic [BYTE_W-1:0] BLANK_CHAR  = 8'h20;
  localparam logic [BYTE_W-1:0] INV_ATTR    = 8'h70;

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT   = 4'd0,
    REQ_PUT    = 4'd1,
    REQ_SCROLL = 4'd2,
    REQ_CLEAR  = 4'd3,
    REQ_CURSOR = 4'd4,
    REQ_VUP    = 4'd5,
    REQ_VDOWN  = 4'd6,
    REQ_VLIVE  = 4'd7,
    REQ_READ   = 4'd8
  } req_e;

  // swap foreground and background of the attribute byte, 0x70 when the swap changes nothing
  function automatic logic [CELL_W-1:0] invert_cell(input logic [CELL_W-1:0] glyph);
    logic [BYTE_W-1:0] attr;
    logic [BYTE_W-1:0] inv;
    attr = glyph[CELL_W-1:BYTE_W];
    inv  = {attr[3:0], 1'b0, attr[6:4]};
    if (inv == attr) begin
      inv = INV_ATTR;
    end
    return {inv, glyph[BYTE_W-1:0]};
  endfunction

endpackage

>>> rtl/tcs_ram.sv
module tcs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/text_console_scrollback.sv
// one item at a time; the next item can be taken in the cycle the result is posted
// the cell loops and address products go through one shared multiplier and the ram ports
// reset: asynchronous, active low; a clearing pass then writes blank cells 0x0720 over the
// screen, and no item is taken during it
module text_console_scrollback (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [tcs_pkg::REQ_W-1:0] req_type_i,
  input  logic [7:0]                char_code_i,
  input  logic [7:0]                color_i,
  input  logic [7:0]                col_x_i,
  input  logic [5:0]                row_y_i,
  input  logic [7:0]                line_count_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                view_offset_o,
  output logic [7:0]                rows_held_o,
  output logic [15:0]               raw_cell_o,
  output logic [15:0]               shown_cell_o,
  output logic                      cursor_on_o,
  output logic [10:0]               cursor_pos_o
);
  import tcs_pkg::*;

  typedef enum logic [9:0] {
    S_FILL = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_CALC = 10'b0000000100,
    S_ACC  = 10'b0000001000,
    S_RDW  = 10'b0000010000,
    S_SCB  = 10'b0000100000,
    S_SCH  = 10'b0001000000,
    S_SCR  = 10'b0010000000,
    S_SCW  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [REQ_W-1:0]  req_q;
  logic [BYTE_W-1:0] ch_q, color_q, x_q, lines_q;
  logic [ROW_W-1:0]  y_q;

  logic [BYTE_W-1:0] used_q, used_d, oldest_q, oldest_d, sb_q, sb_d;
  logic [BYTE_W-1:0] ccol_q, ccol_d;
  logic [ROW_W-1:0]  crow_q, crow_d, top_q, top_d;
  logic [CELL_W-1:0] blank_q, blank_d, raw_q, raw_d;
  logic              fill_cmd_q, fill_cmd_d, hsel_q, hsel_d;
  logic [SCR_AW-1:0] cnt_q, cnt_d;
  logic [BYTE_W-1:0] mul_a_q, mul_a_d;
  logic [PROD_W-1:0] prod;
  logic [SCR_AW-1:0] scr_base_q, scr_base_d;
  logic [HIST_AW-1:0] hist_base_q, hist_base_d;

  logic              out_valid_q;
  logic [BYTE_W-1:0] view_q, held_q;
  logic [CELL_W-1:0] raw_out_q, shown_q;
  logic              con_q;
  logic [POS_W-1:0]  pos_q;

  // ram ports
  logic               scr_we, hist_we;
  logic [SCR_AW-1:0]  scr_waddr, scr_raddr;
  logic [CELL_W-1:0]  scr_wdata, scr_rdata, hist_rdata;
  logic [HIST_AW-1:0] hist_waddr, hist_raddr;

  // helpers
  logic              on_screen, accept, out_free;
  logic [8:0]        line, sum9, vup;
  logic [PROD_W-1:0] acc_addr;
  logic [ROW_W-1:0]  cy;
  logic [BYTE_W-1:0] cx;
  logic [PROD_W-1:0] cpos;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign on_screen  = (x_q < BYTE_W'(COLUMNS)) && (y_q < ROW_W'(ROWS));
  assign out_free   = !out_valid_q || !out_stall_i;

  // shared multiplier: row index times columns
  assign prod     = PROD_W'(mul_a_q) * PROD_W'(COLUMNS);
  assign acc_addr = prod + PROD_W'(x_q);

  tcs_ram #(.WIDTH(CELL_W), .DEPTH(SCR_CELLS)) u_scr_ram (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (scr_waddr),
    .wdata_i (scr_wdata),
    .raddr_i (scr_raddr),
    .rdata_o (scr_rdata)
  );

  tcs_ram #(.WIDTH(CELL_W), .DEPTH(HIST_CELLS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (scr_rdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // clamped cursor position
  assign cy   = (crow_q < ROW_W'(ROWS)) ? crow_q : ROW_W'(ROWS - 1);
  assign cx   = (ccol_q < BYTE_W'(COLUMNS)) ? ccol_q : BYTE_W'(COLUMNS - 1);
  assign cpos = PROD_W'(cy) * PROD_W'(COLUMNS) + PROD_W'(cx);

  // sequencer
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    oldest_d    = oldest_q;
    sb_d        = sb_q;
    ccol_d      = ccol_q;
    crow_d      = crow_q;
    top_d       = top_q;
    blank_d     = blank_q;
    raw_d       = raw_q;
    fill_cmd_d  = fill_cmd_q;
    hsel_d      = hsel_q;
    cnt_d       = cnt_q;
    mul_a_d     = mul_a_q;
    scr_base_d  = scr_base_q;
    hist_base_d = hist_base_q;
    scr_we      = 1'b0;
    scr_waddr   = cnt_q;
    scr_wdata   = blank_q;
    scr_raddr   = SCR_AW'(acc_addr);
    hist_we     = 1'b0;
    hist_waddr  = hist_base_q + HIST_AW'(cnt_q);
    hist_raddr  = HIST_AW'(acc_addr);
    line        = '0;
    sum9        = '0;
    vup         = '0;
    unique case (state_q)
      S_FILL: begin
        scr_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == SCR_AW'(SCR_CELLS - 1)) begin
          state_d = fill_cmd_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          raw_d   = '0;
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        state_d = S_DONE;
        unique case (req_q)
          REQ_INIT, REQ_CLEAR: begin
            blank_d    = {color_q, BLANK_CHAR};
            sb_d       = '0;
            ccol_d     = '0;
            crow_d     = '0;
            cnt_d      = '0;
            fill_cmd_d = 1'b1;
            state_d    = S_FILL;
            if (req_q == REQ_INIT) begin
              used_d   = '0;
              oldest_d = '0;
              top_d    = '0;
            end
          end
          REQ_PUT: begin
            if (on_screen) begin
              sb_d = '0;
              sum9 = 9'(top_q) + 9'(y_q);
              if (sum9 >= 9'(ROWS)) begin
                sum9 = sum9 - 9'(ROWS);
              end
              mul_a_d = BYTE_W'(sum9);
              state_d = S_ACC;
            end
          end
          REQ_SCROLL: begin
            mul_a_d = BYTE_W'(top_q);
            state_d = S_SCB;
          end
          REQ_CURSOR: begin
            ccol_d = x_q;
            crow_d = y_q;
          end
          REQ_VUP: begin
            if (lines_q != '0) begin
              vup  = 9'(sb_q) + 9'(lines_q);
              sb_d = (vup > 9'(used_q)) ? used_q : BYTE_W'(vup);
            end
          end
          REQ_VDOWN: begin
            if (lines_q != '0) begin
              sb_d = (sb_q > lines_q) ? sb_q - lines_q : '0;
            end
          end
          REQ_VLIVE: begin
            sb_d = '0;
          end
          REQ_READ: begin
            if (on_screen) begin
              line = 9'(used_q - sb_q) + 9'(y_q);
              if (line < 9'(used_q)) begin
                sum9 = 9'(oldest_q) + line;
                if (sum9 >= 9'(HIST_ROWS)) begin
                  sum9 = sum9 - 9'(HIST_ROWS);
                end
                hsel_d = 1'b1;
              end else begin
                sum9 = line - 9'(used_q) + 9'(top_q);
                if (sum9 >= 9'(ROWS)) begin
                  sum9 = sum9 - 9'(ROWS);
                end
                hsel_d = 1'b0;
              end
              mul_a_d = BYTE_W'(sum9);
              state_d = S_ACC;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_ACC: begin
        if (req_q == REQ_PUT) begin
          scr_we    = 1'b1;
          scr_waddr = SCR_AW'(acc_addr);
          scr_wdata = {color_q, ch_q};
          state_d   = S_DONE;
        end else begin
          state_d = S_RDW;
        end
      end
      S_RDW: begin
        raw_d   = hsel_q ? hist_rdata : scr_rdata;
        state_d = S_DONE;
      end
      S_SCB: begin
        // top row base, then the history slot it lands in
        scr_base_d = SCR_AW'(prod);
        if (used_q < BYTE_W'(HIST_ROWS)) begin
          sum9 = 9'(oldest_q) + 9'(used_q);
          if (sum9 >= 9'(HIST_ROWS)) begin
            sum9 = sum9 - 9'(HIST_ROWS);
          end
          mul_a_d = BYTE_W'(sum9);
        end else begin
          mul_a_d = oldest_q;
        end
        state_d = S_SCH;
      end
      S_SCH: begin
        hist_base_d = HIST_AW'(prod);
        cnt_d       = '0;
        state_d     = S_SCR;
      end
      S_SCR: begin
        scr_raddr = scr_base_q + cnt_q;
        state_d   = S_SCW;
      end
      S_SCW: begin
        // copy cell to history and blank it in place
        hist_we   = 1'b1;
        scr_we    = 1'b1;
        scr_waddr = scr_base_q + cnt_q;
        cnt_d     = cnt_q + 1'b1;
        state_d   = S_SCR;
        if (cnt_q == SCR_AW'(COLUMNS - 1)) begin
          top_d = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + 1'b1;
          sb_d  = '0;
          if (used_q < BYTE_W'(HIST_ROWS)) begin
            used_d = used_q + 1'b1;
          end else begin
            oldest_d = (oldest_q == BYTE_W'(HIST_ROWS - 1)) ? '0 : oldest_q + 1'b1;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_FILL;
      used_q     <= '0;
      oldest_q   <= '0;
      sb_q       <= '0;
      ccol_q     <= '0;
      crow_q     <= '0;
      top_q      <= '0;
      blank_q    <= BLANK_RESET;
      fill_cmd_q <= 1'b0;
      cnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      oldest_q   <= oldest_d;
      sb_q       <= sb_d;
      ccol_q     <= ccol_d;
      crow_q     <= crow_d;
      top_q      <= top_d;
      blank_q    <= blank_d;
      fill_cmd_q <= fill_cmd_d;
      cnt_q      <= cnt_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item fields, datapath and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_type_i;
      ch_q    <= char_code_i;
      color_q <= color_i;
      x_q     <= col_x_i;
      y_q     <= row_y_i;
      lines_q <= line_count_i;
    end
    raw_q       <= raw_d;
    hsel_q      <= hsel_d;
    mul_a_q     <= mul_a_d;
    scr_base_q  <= scr_base_d;
    hist_base_q <= hist_base_d;
    if (state_q == S_DONE && out_free) begin
      view_q    <= sb_q;
      held_q    <= used_q;
      raw_out_q <= raw_q;
      shown_q   <= (req_q == REQ_READ && on_screen && sb_q == '0 &&
                    x_q == ccol_q && y_q == crow_q) ? invert_cell(raw_q) : raw_q;
      con_q     <= (sb_q == '0);
      pos_q     <= POS_W'(cpos);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign view_offset_o = view_q;
  assign rows_held_o   = held_q;
  assign raw_cell_o    = raw_out_q;
  assign shown_cell_o  = shown_q;
  assign cursor_on_o   = con_q;
  assign cursor_pos_o  = pos_q;

`ifndef NO_ASSERTIONS
  // view offset never runs past the stored history
  a_view_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sb_q <= used_q) else $error("view offset beyond history");

  // history count stays within the ring
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= BYTE_W'(HIST_ROWS)) else $error("history count overflow");

  // a taken item blocks the input on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("input open while busy");

  // cursor flag agrees with the reported offset
  a_cursor_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cursor_on_o == (view_offset_o == '0)))
    else $error("cursor flag mismatch");
`endif

endmodule

>>> verif/text_console_scrollback_tb.sv
`timescale 1ns / 1ps

module text_console_scrollback_tb;
  import tcs_pkg::*;

  localparam int unsigned TIMEOUT_NS = 20_000_000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0]  view_offset;
    logic [7:0]  rows_held;
    logic [15:0] raw_cell;
    logic [15:0] shown_cell;
    logic        cursor_on;
    logic [10:0] cursor_pos;
  } console_status_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [3:0]  req_type_i;
  logic [7:0]  char_code_i;
  logic [7:0]  color_i;
  logic [7:0]  col_x_i;
  logic [5:0]  row_y_i;
  logic [7:0]  line_count_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  view_offset_o;
  logic [7:0]  rows_held_o;
  logic [15:0] raw_cell_o;
  logic [15:0] shown_cell_o;
  logic        cursor_on_o;
  logic [10:0] cursor_pos_o;

  text_console_scrollback uut (.*);

  // mirror of the console contents
  logic [15:0] scr_mirror [SCR_CELLS];
  logic [15:0] hist_mirror [HIST_CELLS];
  int unsigned hist_used;
  int unsigned hist_oldest;
  int unsigned view_back;
  int unsigned cur_col;
  int unsigned cur_row;
  logic [15:0] fill_word;

  console_status_t status_q[$];
  int unsigned     mismatches;
  bit              tx_idle_en;
  bit              rx_idle_en;
  bit              rx_hold;

  // clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // swapped attribute, 0x70 when the swap changes nothing
  function automatic logic [15:0] cursor_look(input logic [15:0] glyph);
    logic [7:0] attr;
    logic [7:0] swapped;
    attr    = glyph[15:8];
    swapped = {attr[3:0], 1'b0, attr[6:4]};
    if (swapped == attr) begin
      swapped = 8'h70;
    end
    return {swapped, glyph[7:0]};
  endfunction

  function automatic logic [15:0] cell_in_view(input int unsigned x, input int unsigned y);
    int unsigned first;
    int unsigned line;
    first = (view_back <= hist_used) ? hist_used - view_back : 0;
    line  = first + y;
    if (line < hist_used) begin
      return hist_mirror[((hist_oldest + line) % HIST_ROWS) * COLUMNS + x];
    end
    line = line - hist_used;
    if (line >= ROWS) begin
      return '0;
    end
    return scr_mirror[line * COLUMNS + x];
  endfunction

  // apply one command to the mirror and queue the status it yields
  function automatic void console_apply(input req_e req, input logic [7:0] ch,
                                        input logic [7:0] color, input logic [7:0] x,
                                        input logic [5:0] y, input logic [7:0] lines);
    console_status_t st;
    bit on_screen;
    int unsigned slot;
    int unsigned cx;
    int unsigned cy;
    on_screen = (x < COLUMNS) && (y < ROWS);
    st = '0;
    case (req)
      REQ_INIT, REQ_CLEAR: begin
        fill_word = {color, 8'h20};
        foreach (scr_mirror[i]) scr_mirror[i] = fill_word;
        if (req == REQ_INIT) begin
          foreach (hist_mirror[i]) hist_mirror[i] = fill_word;
          hist_used   = 0;
          hist_oldest = 0;
        end
        view_back = 0;
        cur_col   = 0;
        cur_row   = 0;
      end
      REQ_PUT: begin
        if (on_screen) begin
          view_back = 0;
          scr_mirror[y * COLUMNS + x] = {color, ch};
        end
      end
      REQ_SCROLL: begin
        if (hist_used < HIST_ROWS) begin
          slot = (hist_oldest + hist_used) % HIST_ROWS;
          hist_used++;
        end else begin
          slot = hist_oldest;
          hist_oldest = (hist_oldest + 1) % HIST_ROWS;
        end
        for (int i = 0; i < COLUMNS; i++) hist_mirror[slot * COLUMNS + i] = scr_mirror[i];
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) scr_mirror[i] = scr_mirror[i + COLUMNS];
        for (int i = 0; i < COLUMNS; i++) scr_mirror[(ROWS - 1) * COLUMNS + i] = fill_word;
        view_back = 0;
      end
      REQ_CURSOR: begin
        cur_col = x;
        cur_row = y;
      end
      REQ_VUP: begin
        if (lines != 0) begin
          view_back += lines;
          if (view_back > hist_used) view_back = hist_used;
        end
      end
      REQ_VDOWN: begin
        if (lines != 0) view_back = (view_back > lines) ? view_back - lines : 0;
      end
      REQ_VLIVE: begin
        view_back = 0;
      end
      REQ_READ: begin
        if (on_screen) begin
          st.raw_cell   = cell_in_view(x, y);
          st.shown_cell = st.raw_cell;
          if (view_back == 0 && x == cur_col && y == cur_row) begin
            st.shown_cell = cursor_look(st.raw_cell);
          end
        end
      end
      default: begin
      end
    endcase
    cx = (cur_col < COLUMNS) ? cur_col : COLUMNS - 1;
    cy = (cur_row < ROWS) ? cur_row : ROWS - 1;
    st.view_offset = view_back[7:0];
    st.rows_held   = hist_used[7:0];
    st.cursor_on   = (view_back == 0);
    st.cursor_pos  = 11'((cy * COLUMNS + cx) & 11'h7FF);
    status_q.push_back(st);
  endfunction

  // offer one item, wait for it to be taken
  task automatic send_cmd(input req_e req, input logic [7:0] ch, input logic [7:0] color,
                          input logic [7:0] x, input logic [5:0] y, input logic [7:0] lines);
    if (tx_idle_en && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    char_code_i  <= ch;
    color_i      <= color;
    col_x_i      <= x;
    row_y_i      <= y;
    line_count_i <= lines;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    console_apply(req, ch, color, x, y, lines);
  endtask

  task automatic quiet_tx();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    quiet_tx();
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    console_status_t got;
    console_status_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {view_offset_o, rows_held_o, raw_cell_o, shown_cell_o, cursor_on_o, cursor_pos_o};
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected result %h", got);
      end else begin
        want = status_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: offset %0d/%0d held %0d/%0d raw %h/%h",
                     want.view_offset, got.view_offset, want.rows_held, got.rows_held,
                     want.raw_cell, got.raw_cell);
            $display("          shown %h/%h on %b/%b pos %0d/%0d",
                     want.shown_cell, got.shown_cell,
                     want.cursor_on, got.cursor_on, want.cursor_pos, got.cursor_pos);
          end
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= rx_hold || (rx_idle_en && $urandom_range(99) < 6);
  end

  task automatic test_init_extremes();
    send_cmd(REQ_READ, 8'h00, 8'h00, 8'd0, 6'd0, 8'd0);
    send_cmd(REQ_INIT, 8'hFF, 8'hFF, 8'hFF, 6'h3F, 8'hFF);
    send_cmd(REQ_READ, 8'h00, 8'h00, 8'd79, 6'd24, 8'd0);
    send_cmd(REQ_INIT, 8'h00, 8'h00, 8'd0, 6'd0, 8'd0);
    send_cmd(REQ_READ, 8'h00, 8'h00, 8'd0, 6'd0, 8'd0);
  endtask

  task automatic test_put_and_read();
    send_cmd(REQ_PUT, 8'hFF, 8'h77, 8'd79, 6'd24, 8'd0);
    send_cmd(REQ_PUT, 8'hA5, 8'h1E, 8'd0, 6'd0, 8'd0);
    send_cmd(REQ_PUT, 8'h41, 8'h12, 8'd80, 6'd3, 8'd0);
    send_cmd(REQ_PUT, 8'h42, 8'h12, 8'd3, 6'd25, 8'd0);
    send_cmd(REQ_READ, 8'h00, 8'h00, 8'd0, 6'd0, 8'd0);
    send_cmd(REQ_READ, 8'h00, 8'h00, 8'd255, 6'd63, 8'd0);
    send_cmd(REQ_CURSOR, 8'h00, 8'h00, 8'd79, 6'd24, 8'd0);
    send_cmd(REQ_READ, 8'h00, 8'h00, 8'd79, 6'd24, 8'd0);
    send_cmd(REQ_CURSOR, 8'h00, 8'h00, 8'd255, 6'd63, 8'd0);
    send_cmd(REQ_READ, 8'h00, 8'h00, 8'd79, 6'd24, 8'd0);
  endtask

  task automatic test_scroll_and_view();
    send_cmd(REQ_SCROLL, 8'h00, 8'h00, 8'd0, 6'd0, 8'd0);
    send_cmd(REQ_SCROLL, 8'h00, 8'h00, 8'd0, 6'd0, 8'd0);
    send_cmd(REQ_VUP, 8'h00, 8'h00, 8'd0, 6'd0, 8'd255);
    send_cmd(REQ_READ, 8'h00, 8'h00, 8'd0, 6'd0, 8'd0);
    send_cmd(REQ_VDOWN, 8'h00, 8'h00, 8'd0, 6'd0, 8'd0);
    send_cmd(REQ_VDOWN, 8'h00, 8'h00, 8'd0, 6'd0, 8'd1);
    send_cmd(REQ_VUP, 8'h00, 8'h00, 8'd0, 6'd0, 8'd0);
    send_cmd(REQ_VLIVE, 8'h00, 8'h00, 8'd0, 6'd0, 8'd0);
    send_cmd(REQ_CLEAR, 8'h00, 8'h80, 8'd0, 6'd0, 8'd0);
    send_cmd(req_e'(4'd15), 8'h00, 8'h00, 8'd0, 6'd0, 8'd0);
  endtask

  // random command mix with well-formed coordinates most of the time
  task automatic random_cmd();
    int unsigned pick;
    req_e req;
    logic [7:0] x;
    logic [5:0] y;
    pick = $urandom_range(999);
    if      (pick < 300) req = REQ_PUT;
    else if (pick < 600) req = REQ_READ;
    else if (pick < 720) req = REQ_SCROLL;
    else if (pick < 800) req = REQ_CURSOR;
    else if (pick < 880) req = REQ_VUP;
    else if (pick < 940) req = REQ_VDOWN;
    else if (pick < 965) req = REQ_VLIVE;
    else if (pick < 975) req = REQ_CLEAR;
    else if (pick < 980) req = REQ_INIT;
    else                 req = req_e'(4'($urandom_range(15, 9)));
    if ($urandom_range(9) < 8) begin
      x = 8'($urandom_range(COLUMNS - 1));
      y = 6'($urandom_range(ROWS - 1));
    end else begin
      x = 8'($urandom);
      y = 6'($urandom);
    end
    if (req == REQ_READ && $urandom_range(3) == 0 && cur_col < COLUMNS && cur_row < ROWS) begin
      x = 8'(cur_col);
      y = 6'(cur_row);
    end
    send_cmd(req, 8'($urandom), 8'($urandom), x, y,
             ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(4)));
  endtask

  task automatic test_random(input int unsigned count);
    for (int i = 0; i < count; i++) begin
      // stretch with no idling on either side
      tx_idle_en = !(i >= count / 3 && i < count / 2);
      rx_idle_en = tx_idle_en;
      random_cmd();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // receiver holds off while commands keep coming
  task automatic test_receiver_hold();
    fork
      begin
        rx_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    for (int i = 0; i < 20; i++) random_cmd();
    wait_drained();
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   <= 1'b0;
    req_type_i   <= '0;
    char_code_i  <= '0;
    color_i      <= '0;
    col_x_i      <= '0;
    row_y_i      <= '0;
    line_count_i <= '0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    rx_hold      = 1'b0;
    mismatches   = 0;
    fill_word    = 16'h0720;
    foreach (scr_mirror[i]) scr_mirror[i] = fill_word;
    foreach (hist_mirror[i]) hist_mirror[i] = '0;
    hist_used   = 0;
    hist_oldest = 0;
    view_back   = 0;
    cur_col     = 0;
    cur_row     = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_init_extremes();
    test_put_and_read();
    test_scroll_and_view();
    wait_drained();
    test_random(900);
    test_receiver_hold();
    test_random(950);
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && status_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
